>>> rtl/rpi_pkg.sv
`default_nettype none

package rpi_pkg;

  localparam int MAX_POINTS_DEF = 512;

  localparam int LAT_W  = 31;
  localparam int LON_W  = 32;
  localparam int DIST_W = 32;
  localparam int OP_W   = 2;
  localparam int WHERE_W = 2;

  // difference of two coordinates, its magnitude, and the divide step count
  localparam int DIFF_W = 33;
  localparam int MAG_W  = 32;
  localparam int STEP_W = $clog2(MAG_W + 1);

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [WHERE_W-1:0] WHERE_INTERP = 2'd0;
  localparam logic [WHERE_W-1:0] WHERE_START  = 2'd1;
  localparam logic [WHERE_W-1:0] WHERE_END    = 2'd2;
  localparam logic [WHERE_W-1:0] WHERE_EMPTY  = 2'd3;

  typedef struct packed {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic [DIST_W-1:0]       cum_dist;
  } point_t;

  // one coordinate of the fused multiply-divide
  typedef struct packed {
    logic                     neg;
    logic [MAG_W-1:0]         mag;
    logic [MAG_W-1:0]         quo;
    logic [DIST_W-1:0]        rem;
    logic signed [DIFF_W-1:0] base;
  } lane_t;

endpackage

`default_nettype wire

>>> rtl/route_position_interpolator_top.sv
// Channel  Direction  Ports                                              Handshake
// in       input      in_op, in_point_lat, in_point_lon, in_distance     in_valid / in_ready
// out      output     out_pos_lat, out_pos_lon, out_where                out_valid / out_ready
//
// Append and clear requests complete on acceptance and leave the block ready. A query
// scans the point memory one entry per cycle through its single registered read port;
// an interpolated result then runs the fused multiply-divide (S_DIV), and every result
// is loaded into the output register from S_OUT. No request is taken until the query ends.
// Synchronous active-low reset empties the route; the memory is not cleared.
// A result waits in the output register while further requests are taken; a
// new query result waits until that register is free.
`default_nettype none

module route_position_interpolator_top
  import rpi_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic [OP_W-1:0]           in_op,
  input  wire logic signed [LAT_W-1:0]   in_point_lat,
  input  wire logic signed [LON_W-1:0]   in_point_lon,
  input  wire logic [DIST_W-1:0]         in_distance,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic signed [LAT_W-1:0]   out_pos_lat,
  output      logic signed [LON_W-1:0]   out_pos_lon,
  output      logic [WHERE_W-1:0]        out_where
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_POINTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_SCAN,
    S_DIV,
    S_OUT
  } state_t;

  state_t                   state_r;
  logic [CNT_W-1:0]         count_r;
  logic [DIST_W-1:0]        route_len_r;
  logic [DIST_W-1:0]        qdist_r;
  logic [CNT_W-1:0]         chk_idx_r;
  point_t                   prev_r;
  point_t                   rd_data_r;
  lane_t                    lat_lane_r;
  lane_t                    lon_lane_r;
  logic [DIST_W-1:0]        off_r;
  logic [DIST_W-1:0]        seg_r;
  logic [STEP_W-1:0]        step_r;
  logic signed [LAT_W-1:0]  res_lat_r;
  logic signed [LON_W-1:0]  res_lon_r;
  logic [WHERE_W-1:0]       res_where_r;
  logic                     out_valid_r;
  logic signed [LAT_W-1:0]  out_lat_r;
  logic signed [LON_W-1:0]  out_lon_r;
  logic [WHERE_W-1:0]       out_where_r;

  point_t                   mem [MAX_POINTS];

  logic                     in_acc;
  logic                     wr_en;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic [CNT_W-1:0]         last_idx;
  logic [CNT_W-1:0]         next_idx;
  logic                     hit;
  logic                     slot_free;
  lane_t                    lat_step;
  lane_t                    lon_step;
  logic signed [DIFF_W-1:0] lat_fin;
  logic signed [DIFF_W-1:0] lon_fin;

  function automatic lane_t lane_init(input logic signed [DIFF_W-1:0] a,
                                      input logic signed [DIFF_W-1:0] b);
    lane_t                    l;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;
    diff   = b - a;
    mag    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    l.neg  = diff[DIFF_W-1];
    l.mag  = mag[MAG_W-1:0];
    l.quo  = '0;
    l.rem  = '0;
    l.base = a;
    return l;
  endfunction

  // one Horner step of floor(mag * off / seg); rem stays below seg, digit is 0..2
  function automatic lane_t div_step(input lane_t l, input logic [DIST_W-1:0] off,
                                     input logic [DIST_W-1:0] seg);
    lane_t             n;
    logic [DIST_W+1:0] t;
    logic [DIST_W+1:0] s1;
    logic [DIST_W+1:0] s2;
    logic [1:0]        dig;
    n  = l;
    t  = {1'b0, l.rem, 1'b0} + {2'b00, (l.mag[MAG_W-1] ? off : {DIST_W{1'b0}})};
    s1 = {2'b00, seg};
    s2 = {1'b0, seg, 1'b0};
    if (t >= s2) begin
      n.rem = DIST_W'(t - s2);
      dig   = 2'd2;
    end else if (t >= s1) begin
      n.rem = DIST_W'(t - s1);
      dig   = 2'd1;
    end else begin
      n.rem = t[DIST_W-1:0];
      dig   = 2'd0;
    end
    n.quo = {l.quo[MAG_W-2:0], 1'b0} + {{(MAG_W-2){1'b0}}, dig};
    n.mag = {l.mag[MAG_W-2:0], 1'b0};
    return n;
  endfunction

  function automatic logic signed [DIFF_W-1:0] lane_result(input lane_t l);
    logic signed [DIFF_W-1:0] q;
    q = {1'b0, l.quo};
    return l.neg ? l.base - q : l.base + q;
  endfunction

  function automatic logic signed [DIFF_W-1:0] ext_lat(input logic signed [LAT_W-1:0] v);
    return {{(DIFF_W-LAT_W){v[LAT_W-1]}}, v};
  endfunction

  function automatic logic signed [DIFF_W-1:0] ext_lon(input logic signed [LON_W-1:0] v);
    return {{(DIFF_W-LON_W){v[LON_W-1]}}, v};
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign wr_en     = in_acc && (in_op == OP_APPEND) && (count_r < CAP);
  assign last_idx  = count_r - 1'b1;
  assign next_idx  = chk_idx_r + 1'b1;
  assign hit       = (chk_idx_r != '0) && (rd_data_r.cum_dist >= qdist_r);
  assign slot_free = !out_valid_r || out_ready;
  assign lat_step  = div_step(lat_lane_r, off_r, seg_r);
  assign lon_step  = div_step(lon_lane_r, off_r, seg_r);
  assign lat_fin   = lane_result(lat_lane_r);
  assign lon_fin   = lane_result(lon_lane_r);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state_r)
      S_IDLE: begin
        rd_en = in_acc && (in_op == OP_QUERY);
      end
      S_SCAN: begin
        // fetch the next entry while the current one is checked
        rd_en   = !hit && (chk_idx_r != last_idx);
        rd_addr = next_idx[IDX_W-1:0];
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= '{lat: in_point_lat, lon: in_point_lon, cum_dist: in_distance};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      route_len_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one loads in this cycle
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_op)
              OP_APPEND: begin
                if (count_r < CAP) begin
                  count_r     <= count_r + 1'b1;
                  route_len_r <= in_distance;
                end
              end
              OP_CLEAR: begin
                count_r     <= '0;
                route_len_r <= '0;
              end
              OP_QUERY: begin
                qdist_r   <= in_distance;
                chk_idx_r <= '0;
                if (count_r == '0) begin
                  res_lat_r   <= '0;
                  res_lon_r   <= '0;
                  res_where_r <= WHERE_EMPTY;
                  state_r     <= S_OUT;
                end else if (in_distance == '0 || route_len_r == '0) begin
                  state_r <= S_FIRST;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_FIRST: begin
          res_lat_r   <= rd_data_r.lat;
          res_lon_r   <= rd_data_r.lon;
          res_where_r <= WHERE_START;
          state_r     <= S_OUT;
        end
        S_SCAN: begin
          if (hit) begin
            res_lat_r   <= prev_r.lat;
            res_lon_r   <= prev_r.lon;
            res_where_r <= WHERE_INTERP;
            if (rd_data_r.cum_dist > prev_r.cum_dist && qdist_r > prev_r.cum_dist) begin
              seg_r      <= rd_data_r.cum_dist - prev_r.cum_dist;
              off_r      <= qdist_r - prev_r.cum_dist;
              lat_lane_r <= lane_init(ext_lat(prev_r.lat), ext_lat(rd_data_r.lat));
              lon_lane_r <= lane_init(ext_lon(prev_r.lon), ext_lon(rd_data_r.lon));
              step_r     <= STEP_W'(MAG_W);
              state_r    <= S_DIV;
            end else begin
              state_r <= S_OUT;
            end
          end else if (chk_idx_r == last_idx) begin
            res_lat_r   <= rd_data_r.lat;
            res_lon_r   <= rd_data_r.lon;
            res_where_r <= WHERE_END;
            state_r     <= S_OUT;
          end else begin
            prev_r    <= rd_data_r;
            chk_idx_r <= next_idx;
          end
        end
        S_DIV: begin
          if (step_r != '0) begin
            lat_lane_r <= lat_step;
            lon_lane_r <= lon_step;
            step_r     <= step_r - 1'b1;
          end else begin
            res_lat_r <= lat_fin[LAT_W-1:0];
            res_lon_r <= lon_fin[LON_W-1:0];
            state_r   <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_lat_r   <= res_lat_r;
            out_lon_r   <= res_lon_r;
            out_where_r <= res_where_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pos_lat = out_lat_r;
  assign out_pos_lon = out_lon_r;
  assign out_where   = out_where_r;

endmodule

`default_nettype wire
